### rtl/mss_pkg.sv
// Package with constants, codes and types of the multi-stack shared store.
package mss_pkg;

  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 16;

  localparam int WordW    = 32;
  localparam int SidW     = 2;
  localparam int PtrW     = $clog2(CAPACITY + 1);
  localparam int SlotW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HeadSelW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PtrW-1:0]  NullPtr       = PtrW'(CAPACITY);
  localparam logic [WordW-1:0] UnderflowWord = 32'h7FFF_FFFF;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef logic [PtrW-1:0] ptr_t;

endpackage

### rtl/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mss_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/multi_stack_shared_store_top.sv
// Top level of the multi-stack shared store: linked stacks over one slot RAM.
//
// Four last-in-first-out stacks share sixteen data slots. Each slot has a link
// word; free slots form a free list, and each stack keeps a head pointer.
// Input channel (in_valid_i / in_ready_o): command_i (0 push, 1 pop),
// stack_id_i and push_value_i. Output channel (out_valid_o / out_ready_i):
// pop_value_o, status_o (0 ok, 1 overflow, 2 underflow), store_full_o and
// stack_empty_o. Each transaction on the input gives exactly one transaction
// on the output.
// Each input passes through the exec state, which updates links and heads and
// issues the slot RAM access, and then the response state, which takes the
// registered RAM read data into the output register; no input is taken in exec.
// The output register holds a finished result while the receiver stalls; the
// next input is taken as soon as the output register is free or being emptied.
// Reset: all stacks empty, free list runs through slots 0 to 15 in order.
// Slot data needs no clearing; a pop only reads a slot that a push wrote.
module multi_stack_shared_store_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [mss_pkg::SidW-1:0]         stack_id_i,
  input  logic signed [mss_pkg::WordW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mss_pkg::WordW-1:0] pop_value_o,
  output logic [1:0]                       status_o,
  output logic                             store_full_o,
  output logic                             stack_empty_o
);

  import mss_pkg::*;

  state_e state_q, state_d;

  cmd_e             cmd_q;
  logic [SidW-1:0]  sid_q;
  logic [WordW-1:0] word_q;

  ptr_t link_q [CAPACITY];
  ptr_t head_q [NUM_STACKS];
  ptr_t free_q;

  status_e res_status_q, res_status_d;
  logic    res_full_q, res_full_d;
  logic    res_empty_q, res_empty_d;
  logic    pop_ok_q, pop_ok_d;

  logic             out_valid_q;
  logic [WordW-1:0] out_value_q;
  status_e          out_status_q;
  logic             out_full_q;
  logic             out_empty_q;

  logic                accept;
  logic                out_load;
  logic                do_exec;
  logic                id_ok;
  logic [HeadSelW-1:0] hsel;
  ptr_t                head_cur;
  ptr_t                head_nxt;
  ptr_t                free_nxt;
  logic                push_ok;
  logic                pop_ok;
  logic [SlotW-1:0]    free_slot;
  logic [SlotW-1:0]    head_slot;
  logic [WordW-1:0]    rd_data;

  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign accept   = in_valid_i && in_ready_o;
  assign do_exec  = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  begin
        if (out_load) begin
          state_d = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_RESP:  in_ready_o = out_load;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign id_ok     = 32'(sid_q) < 32'(NUM_STACKS);
  assign hsel      = HeadSelW'(sid_q);
  assign head_cur  = head_q[hsel];
  assign free_slot = free_q[SlotW-1:0];
  assign head_slot = head_cur[SlotW-1:0];
  assign push_ok   = (cmd_q == CMD_PUSH) && id_ok && (free_q < NullPtr);
  assign pop_ok    = (cmd_q == CMD_POP) && id_ok && (head_cur < NullPtr);

  always_comb begin
    free_nxt     = free_q;
    head_nxt     = head_cur;
    res_status_d = STAT_OK;
    pop_ok_d     = 1'b0;
    if (cmd_q == CMD_PUSH) begin
      if (push_ok) begin
        free_nxt = link_q[free_slot];
        head_nxt = free_q;
      end else begin
        res_status_d = STAT_OVERFLOW;
      end
    end else begin
      if (pop_ok) begin
        head_nxt = link_q[head_slot];
        free_nxt = head_cur;
        pop_ok_d = 1'b1;
      end else begin
        res_status_d = STAT_UNDERFLOW;
      end
    end
    res_full_d  = !(free_nxt < NullPtr);
    res_empty_d = !(id_ok && (head_nxt < NullPtr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        link_q[i] <= PtrW'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        head_q[s] <= NullPtr;
      end
    end else begin
      state_q <= state_d;
      if (do_exec && push_ok) begin
        free_q            <= free_nxt;
        link_q[free_slot] <= head_cur;
        head_q[hsel]      <= head_nxt;
      end else if (do_exec && pop_ok) begin
        free_q            <= free_nxt;
        link_q[head_slot] <= free_q;
        head_q[hsel]      <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      sid_q  <= stack_id_i;
      word_q <= push_value_i;
    end
    if (do_exec) begin
      res_status_q <= res_status_d;
      res_full_q   <= res_full_d;
      res_empty_q  <= res_empty_d;
      pop_ok_q     <= pop_ok_d;
    end
  end

  mss_ram #(
    .Width(WordW),
    .Depth(CAPACITY)
  ) u_slot_data (
    .clk_i    (clk_i),
    .wr_en_i  (do_exec && push_ok),
    .wr_addr_i(free_slot),
    .wr_data_i(word_q),
    .rd_en_i  (do_exec && pop_ok),
    .rd_addr_i(head_slot),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (pop_ok_q) begin
        out_value_q <= rd_data;
      end else if (res_status_q == STAT_UNDERFLOW) begin
        out_value_q <= UnderflowWord;
      end else begin
        out_value_q <= '0;
      end
      out_status_q <= res_status_q;
      out_full_q   <= res_full_q;
      out_empty_q  <= res_empty_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = out_value_q;
  assign status_o      = out_status_q;
  assign store_full_o  = out_full_q;
  assign stack_empty_o = out_empty_q;

  a_exec_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_RESP)
    else $error("exec state not followed by response state");

  a_no_ready_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !in_ready_o)
    else $error("input ready while an operation is in flight");

  a_head_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && free_q < NullPtr) |-> head_cur != free_q)
    else $error("stack head points at the free head");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_OVERFLOW) |-> store_full_o)
    else $error("overflow reported while store not full");

  a_underflow_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_UNDERFLOW)
      |-> (stack_empty_o && pop_value_o == UnderflowWord))
    else $error("underflow result malformed");

endmodule

### test/tb_multi_stack_shared_store_top.sv
// Testbench of the multi-stack shared store: directed and random push/pop traffic checked by a scoreboard.
module tb_multi_stack_shared_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 217;
  localparam int BURST_ITEMS  = 40;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    logic signed [WordW-1:0] value;
    status_e                 status;
    logic                    full;
    logic                    empty;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [WordW-1:0] slot_word [CAPACITY];
    ptr_t                    slot_next [CAPACITY];
    ptr_t                    top_slot  [NUM_STACKS];
    ptr_t                    free_top;
    stack_result_t           expected_q [$];
    int                      errors;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        slot_word[i] = '0;
        slot_next[i] = ptr_t'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        top_slot[s] = NullPtr;
      end
      free_top = '0;
      errors   = 0;
    endfunction

    function void note_input(cmd_e cmd, logic [SidW-1:0] sid, logic signed [WordW-1:0] word);
      stack_result_t res;
      ptr_t          slot;
      bit            id_ok;
      id_ok      = int'(sid) < NUM_STACKS;
      res.value  = '0;
      res.status = STAT_OK;
      if (cmd == CMD_PUSH) begin
        if (!id_ok || free_top >= CAPACITY) begin
          res.status = STAT_OVERFLOW;
        end else begin
          slot            = free_top;
          free_top        = slot_next[slot];
          slot_next[slot] = top_slot[sid];
          top_slot[sid]   = slot;
          slot_word[slot] = word;
        end
      end else begin
        if (!id_ok || top_slot[sid] >= CAPACITY) begin
          res.status = STAT_UNDERFLOW;
          res.value  = UnderflowWord;
        end else begin
          slot            = top_slot[sid];
          top_slot[sid]   = slot_next[slot];
          slot_next[slot] = free_top;
          free_top        = slot;
          res.value       = slot_word[slot];
        end
      end
      res.full  = (free_top >= CAPACITY);
      res.empty = !(id_ok && top_slot[sid] < CAPACITY);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic signed [WordW-1:0] value, logic [1:0] status,
                               logic full, logic empty);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with no operation pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        $error("pop_value expected %0d actual %0d", want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, status);
        errors++;
      end
      if (full !== want.full) begin
        $error("store_full expected %0b actual %0b", want.full, full);
        errors++;
      end
      if (empty !== want.empty) begin
        $error("stack_empty expected %0b actual %0b", want.empty, empty);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    command_i;
  logic [SidW-1:0]         stack_id_i;
  logic signed [WordW-1:0] push_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [WordW-1:0] pop_value_o;
  logic [1:0]              status_o;
  logic                    store_full_o;
  logic                    stack_empty_o;

  stack_scoreboard sb;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              cycle_count;

  logic signed [WordW-1:0] corner_words [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};

  multi_stack_shared_store_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .stack_id_i   (stack_id_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .store_full_o (store_full_o),
    .stack_empty_o(stack_empty_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(pop_value_o, status_o, store_full_o, stack_empty_o);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic issue_op(cmd_e cmd, logic [SidW-1:0] sid, logic signed [WordW-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    stack_id_i   <= sid;
    push_value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, sid, word);
  endtask

  // hold off new operations until every pending result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int                      push_pct;
    cmd_e                    cmd;
    logic signed [WordW-1:0] word;
    for (int n = 0; n < count; n++) begin
      case ((n / BURST_ITEMS) % 3)
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      cmd  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      word = ($urandom_range(7) == 0) ? corner_words[$urandom_range(3)] : $urandom;
      issue_op(cmd, SidW'($urandom_range(NUM_STACKS - 1)), word);
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = 1'b0;
    stack_id_i   = '0;
    push_value_i = '0;
    out_ready_i  = 1'b0;
    cycle_count  = 0;
    tx_idle_pct  = 28;
    rx_idle_pct  = 57;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_op(CMD_POP, SidW'(0), 32'sh0);
    issue_op(CMD_PUSH, SidW'(0), 32'sh8000_0000);
    issue_op(CMD_PUSH, SidW'(1), 32'sh7FFF_FFFF);
    issue_op(CMD_PUSH, SidW'(2), -32'sd1);
    issue_op(CMD_PUSH, SidW'(3), 32'sh0);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      issue_op(CMD_PUSH, SidW'(i % NUM_STACKS), i[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA);
    end
    issue_op(CMD_PUSH, SidW'(1), 32'sh1234_5678);
    for (int s = 0; s < NUM_STACKS; s++) begin
      issue_op(CMD_POP, SidW'(s), 32'sh0);
    end
    issue_op(CMD_POP, SidW'(2), -32'sd1);
    drain();

    run_random(PHASE_ITEMS);
    drain();
    tx_idle_pct = 57;
    rx_idle_pct = 28;
    run_random(PHASE_ITEMS);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE_ITEMS);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
